// ===== rtl/tbq_pkg.sv =====
// shared types, codes and constants of the two-phase transmit buffer queue
package tbq_pkg;

    localparam int CAPACITY_DEF = 31;
    localparam int DEV_W        = 3;
    localparam int HANDLE_W     = 32;
    localparam int COUNT_W      = 5;
    localparam int LOST_W       = 16;

    // request codes
    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_ADV = 2'd1;
    localparam logic [1:0] REQ_DEQ = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_SUBMIT = 2'd2,
        ST_NO_DONE   = 2'd3
    } status_t;

    typedef struct packed {
        logic [DEV_W-1:0]    dev;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // queue summary after one transaction
    typedef struct packed {
        status_t             status;
        logic                item_ok;
        logic                submit_pending;
        logic                complete_pending;
        logic [COUNT_W-1:0]  count_total;
        logic [COUNT_W-1:0]  count_phase_one;
        logic [LOST_W-1:0]   lost_count;
        logic [COUNT_W-1:0]  max_total;
        logic [COUNT_W-1:0]  max_phase_one;
    } step_sum_t;

endpackage

// ===== rtl/tbq_if.sv =====
// valid/ready channel interfaces for requests and responses

interface tbq_req_if;
    import tbq_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [DEV_W-1:0]    dev_index;
    logic [HANDLE_W-1:0] buffer_handle;

    modport source (output valid, output req_type, output dev_index,
                    output buffer_handle, input ready);
    modport sink   (input valid, input req_type, input dev_index,
                    input buffer_handle, output ready);
endinterface

interface tbq_rsp_if;
    import tbq_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [DEV_W-1:0]    item_dev;
    logic [HANDLE_W-1:0] item_handle;
    logic                submit_pending;
    logic [DEV_W-1:0]    submit_dev;
    logic [HANDLE_W-1:0] submit_handle;
    logic                complete_pending;
    logic [COUNT_W-1:0]  count_total;
    logic [COUNT_W-1:0]  count_phase_one;
    logic [LOST_W-1:0]   lost_count;
    logic [COUNT_W-1:0]  max_total;
    logic [COUNT_W-1:0]  max_phase_one;

    modport source (output valid, output status, output item_dev, output item_handle,
                    output submit_pending, output submit_dev, output submit_handle,
                    output complete_pending, output count_total, output count_phase_one,
                    output lost_count, output max_total, output max_phase_one,
                    input ready);
    modport sink   (input valid, input status, input item_dev, input item_handle,
                    input submit_pending, input submit_dev, input submit_handle,
                    input complete_pending, input count_total, input count_phase_one,
                    input lost_count, input max_total, input max_phase_one,
                    output ready);
endinterface

// ===== rtl/tbq_mem.sv =====
// descriptor ring storage: one write port, two registered read ports
module tbq_mem #(
    parameter int DEPTH = tbq_pkg::CAPACITY_DEF + 1,
    parameter int AW    = $clog2(tbq_pkg::CAPACITY_DEF + 1)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tbq_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_a_addr,
    input  logic [AW-1:0]   rd_b_addr,
    output tbq_pkg::entry_t rd_a_data,
    output tbq_pkg::entry_t rd_b_data
);
    import tbq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

// ===== rtl/tbq_ptrs.sv =====
// ring pointers, fill statistics and per-transaction decision logic
module tbq_ptrs #(
    parameter int CAPACITY = tbq_pkg::CAPACITY_DEF,
    parameter int PTR_W    = $clog2(tbq_pkg::CAPACITY_DEF + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         req_type,
    output logic               wr_en,
    output logic [PTR_W-1:0]   wr_addr,
    output logic [PTR_W-1:0]   item_addr,
    output logic [PTR_W-1:0]   submit_addr,
    output logic               bypass,
    output tbq_pkg::step_sum_t sum
);
    import tbq_pkg::*;

    localparam int SLOTS = CAPACITY + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY);

    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [PTR_W-1:0]  sub_reg, sub_next;
    logic [PTR_W-1:0]  done_reg, done_next;
    logic [LOST_W-1:0] lost_reg, lost_next;
    logic [PTR_W-1:0]  peak_reg, peak_next;
    logic [PTR_W-1:0]  peak1_reg, peak1_next;
    logic [PTR_W-1:0]  total_next, phase1_next;
    logic              enq_ok;
    status_t           status;
    logic              item_ok;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                   input logic [PTR_W-1:0] b);
        logic [PTR_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (a < b)
        begin
            d = d + (PTR_W+1)'(SLOTS);
        end
        return d[PTR_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] fit_count(input logic [PTR_W-1:0] c);
        logic [PTR_W+COUNT_W-1:0] ext;
        ext = {{COUNT_W{1'b0}}, c};
        return ext[COUNT_W-1:0];
    endfunction

    always_comb
    begin
        tail_next  = tail_reg;
        sub_next   = sub_reg;
        done_next  = done_reg;
        lost_next  = lost_reg;
        peak_next  = peak_reg;
        peak1_next = peak1_reg;
        status     = ST_OK;
        item_ok    = 1'b0;
        enq_ok     = 1'b0;
        item_addr  = sub_reg;

        case (req_type)
            REQ_ENQ:
            begin
                if (ring_next(tail_reg) == done_reg)
                begin
                    status = ST_FULL;
                    if (lost_reg != '1)
                    begin
                        lost_next = lost_reg + 1'b1;
                    end
                end
                else
                begin
                    enq_ok    = 1'b1;
                    tail_next = ring_next(tail_reg);
                end
            end
            REQ_ADV:
            begin
                if (sub_reg == tail_reg)
                begin
                    status = ST_NO_SUBMIT;
                end
                else
                begin
                    item_ok   = 1'b1;
                    item_addr = sub_reg;
                    sub_next  = ring_next(sub_reg);
                end
            end
            REQ_DEQ:
            begin
                if (done_reg == sub_reg)
                begin
                    status = ST_NO_DONE;
                end
                else
                begin
                    item_ok   = 1'b1;
                    item_addr = done_reg;
                    done_next = ring_next(done_reg);
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        total_next  = ring_dist(tail_next, done_next);
        phase1_next = ring_dist(tail_next, sub_next);

        // only an enqueue can raise a fill level
        if (enq_ok)
        begin
            if (total_next > peak_reg)
            begin
                peak_next = total_next;
            end
            if (phase1_next > peak1_reg)
            begin
                peak1_next = phase1_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg  <= '0;
            sub_reg   <= '0;
            done_reg  <= '0;
            lost_reg  <= '0;
            peak_reg  <= '0;
            peak1_reg <= '0;
        end
        else if (step)
        begin
            tail_reg  <= tail_next;
            sub_reg   <= sub_next;
            done_reg  <= done_next;
            lost_reg  <= lost_next;
            peak_reg  <= peak_next;
            peak1_reg <= peak1_next;
        end
    end

    assign wr_en       = step && enq_ok;
    assign wr_addr     = tail_reg;
    assign submit_addr = sub_next;
    // phase one was empty: the new oldest entry is the one being written now
    assign bypass      = enq_ok && (sub_reg == tail_reg);

    always_comb
    begin
        sum.status           = status;
        sum.item_ok          = item_ok;
        sum.submit_pending   = (sub_next != tail_next);
        sum.complete_pending = (done_next != sub_next);
        sum.count_total      = fit_count(total_next);
        sum.count_phase_one  = fit_count(phase1_next);
        sum.lost_count       = lost_next;
        sum.max_total        = fit_count(peak_next);
        sum.max_phase_one    = fit_count(peak1_next);
    end

`ifndef SYNTHESIS
    a_phase_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        ring_dist(tail_reg, sub_reg) <= ring_dist(tail_reg, done_reg))
        else $error("phase-one fill exceeds total fill");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ring_dist(tail_reg, done_reg) <= LAST_PTR)
        else $error("fill exceeds capacity");

    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        (peak_reg >= ring_dist(tail_reg, done_reg))
        && (peak1_reg >= ring_dist(tail_reg, sub_reg)))
        else $error("peak fill below current fill");

    a_lost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> lost_reg >= $past(lost_reg))
        else $error("lost count decreased");
`endif

endmodule

// ===== rtl/two_phase_tx_buffer_queue_unit.sv =====
// top level of the two-phase transmit buffer queue
//
// Ring queue of up to CAPACITY transmit descriptors (device index and buffer
// handle), split by three pointers into entries waiting for submission
// (phase one) and entries waiting for completion (phase two). A request
// transaction enqueues, advances the oldest phase-one entry or dequeues the
// oldest phase-two entry; every request yields exactly one response
// transaction carrying the status, the entry advanced or dequeued, the next
// entry to submit, fill counts and statistics. The descriptors live in a
// synchronous memory with registered read data, so the unit takes no new
// request until the response of the last one has moved into the output
// register. A finished response sits in the output register until taken;
// while a second response would have nowhere to go, the unit also holds
// off further requests. Counts and peaks are reported modulo 32; the lost
// count saturates at 65535.
module two_phase_tx_buffer_queue_unit #(
    parameter int CAPACITY = tbq_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tbq_req_if.sink   req,
    tbq_rsp_if.source rsp
);
    import tbq_pkg::*;

    localparam int SLOTS = CAPACITY + 1;
    localparam int PTR_W = $clog2(SLOTS);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } state_t;

    state_t              state_reg;
    step_sum_t           sum_reg;
    logic                bypass_reg;
    entry_t              byp_data_reg;

    // response output register
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [DEV_W-1:0]    out_item_dev_reg;
    logic [HANDLE_W-1:0] out_item_handle_reg;
    logic                out_sub_pend_reg;
    logic [DEV_W-1:0]    out_sub_dev_reg;
    logic [HANDLE_W-1:0] out_sub_handle_reg;
    logic                out_cmp_pend_reg;
    logic [COUNT_W-1:0]  out_total_reg;
    logic [COUNT_W-1:0]  out_phase1_reg;
    logic [LOST_W-1:0]   out_lost_reg;
    logic [COUNT_W-1:0]  out_max_total_reg;
    logic [COUNT_W-1:0]  out_max_phase1_reg;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [PTR_W-1:0]    item_addr;
    logic [PTR_W-1:0]    submit_addr;
    logic                bypass;
    step_sum_t           sum;
    entry_t              wr_data;
    entry_t              rd_a_data;
    entry_t              rd_b_data;
    entry_t              sub_entry;
    logic [DEV_W-1:0]    item_dev;
    logic [HANDLE_W-1:0] item_handle;
    logic [DEV_W-1:0]    sub_dev;
    logic [HANDLE_W-1:0] sub_handle;

    // a request is taken only between transactions
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    // the finished response moves into the output register this cycle
    assign out_load  = (state_reg == S_RESP) && out_free;

    assign wr_data.dev    = req.dev_index;
    assign wr_data.handle = req.buffer_handle;

    // pointer bookkeeping: decides the transaction and updates on accept
    tbq_ptrs #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W)
    ) u_ptrs (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .req_type    (req.req_type),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .item_addr   (item_addr),
        .submit_addr (submit_addr),
        .bypass      (bypass),
        .sum         (sum)
    );

    // port a reads the item moved out, port b the next entry to submit
    tbq_mem #(
        .DEPTH (SLOTS),
        .AW    (PTR_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_a_addr (item_addr),
        .rd_b_addr (submit_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // the slot written in the same cycle reads stale, so forward the new entry
    assign sub_entry   = bypass_reg ? byp_data_reg : rd_b_data;
    assign item_dev    = sum_reg.item_ok ? rd_a_data.dev : '0;
    assign item_handle = sum_reg.item_ok ? rd_a_data.handle : '0;
    assign sub_dev     = sum_reg.submit_pending ? sub_entry.dev : '0;
    assign sub_handle  = sum_reg.submit_pending ? sub_entry.handle : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            sum_reg             <= '0;
            bypass_reg          <= 1'b0;
            byp_data_reg        <= '0;
            out_valid_reg       <= 1'b0;
            out_status_reg      <= ST_OK;
            out_item_dev_reg    <= '0;
            out_item_handle_reg <= '0;
            out_sub_pend_reg    <= 1'b0;
            out_sub_dev_reg     <= '0;
            out_sub_handle_reg  <= '0;
            out_cmp_pend_reg    <= 1'b0;
            out_total_reg       <= '0;
            out_phase1_reg      <= '0;
            out_lost_reg        <= '0;
            out_max_total_reg   <= '0;
            out_max_phase1_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sum_reg      <= sum;
                        bypass_reg   <= bypass;
                        byp_data_reg <= wr_data;
                        state_reg    <= S_RESP;
                    end
                end
                S_RESP:
                begin
                    // wait here while the previous response is still unclaimed
                    if (out_free)
                    begin
                        out_status_reg      <= sum_reg.status;
                        out_item_dev_reg    <= item_dev;
                        out_item_handle_reg <= item_handle;
                        out_sub_pend_reg    <= sum_reg.submit_pending;
                        out_sub_dev_reg     <= sub_dev;
                        out_sub_handle_reg  <= sub_handle;
                        out_cmp_pend_reg    <= sum_reg.complete_pending;
                        out_total_reg       <= sum_reg.count_total;
                        out_phase1_reg      <= sum_reg.count_phase_one;
                        out_lost_reg        <= sum_reg.lost_count;
                        out_max_total_reg   <= sum_reg.max_total;
                        out_max_phase1_reg  <= sum_reg.max_phase_one;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.item_dev         = out_item_dev_reg;
    assign rsp.item_handle      = out_item_handle_reg;
    assign rsp.submit_pending   = out_sub_pend_reg;
    assign rsp.submit_dev       = out_sub_dev_reg;
    assign rsp.submit_handle    = out_sub_handle_reg;
    assign rsp.complete_pending = out_cmp_pend_reg;
    assign rsp.count_total      = out_total_reg;
    assign rsp.count_phase_one  = out_phase1_reg;
    assign rsp.lost_count       = out_lost_reg;
    assign rsp.max_total        = out_max_total_reg;
    assign rsp.max_phase_one    = out_max_phase1_reg;

`ifndef SYNTHESIS
    a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_RESP)
        else $error("accepted request did not start a response");

    a_resp_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("response produced without a pending request");

    a_item_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |->
        (out_item_dev_reg == '0) && (out_item_handle_reg == '0))
        else $error("item reported for a refused request");
`endif

endmodule

// ===== sim/two_phase_tx_buffer_queue_unit_tb.sv =====
// self-checking testbench of the two-phase transmit buffer queue unit
`timescale 1ns / 1ps

module two_phase_tx_buffer_queue_unit_tb;
    import tbq_pkg::*;

    // request code the unit ignores, answered with a plain status
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int RING_SLOTS = CAPACITY_DEF + 1;
    localparam int RANDOM_ITEMS = 360;
    localparam int FULL_DROPS = 10;

    // request mixes of the random segments
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_FLOW
    } mix_t;

    // one response transaction, field for field
    typedef struct packed {
        status_t             status;
        logic [DEV_W-1:0]    item_dev;
        logic [HANDLE_W-1:0] item_handle;
        logic                submit_pending;
        logic [DEV_W-1:0]    submit_dev;
        logic [HANDLE_W-1:0] submit_handle;
        logic                complete_pending;
        logic [COUNT_W-1:0]  count_total;
        logic [COUNT_W-1:0]  count_phase_one;
        logic [LOST_W-1:0]   lost_count;
        logic [COUNT_W-1:0]  max_total;
        logic [COUNT_W-1:0]  max_phase_one;
    } queue_rsp_t;

    // shadow of the descriptor ring and the responses it owes
    class tx_ring_tracker;
        logic [DEV_W-1:0]    slot_dev [RING_SLOTS];
        logic [HANDLE_W-1:0] slot_handle [RING_SLOTS];
        bit [COUNT_W-1:0]    tail;
        bit [COUNT_W-1:0]    done_head;
        bit [COUNT_W-1:0]    submit_head;
        bit [LOST_W-1:0]     dropped;
        bit [COUNT_W-1:0]    peak_total;
        bit [COUNT_W-1:0]    peak_one;
        queue_rsp_t          due_responses [$];
        int                  mismatches;
        int                  checked;
        int                  req_seen [4];
        int                  status_seen [4];

        // work out the response of one accepted request and queue it
        function void take_request(logic [1:0] kind, logic [DEV_W-1:0] dev,
                                   logic [HANDLE_W-1:0] handle);
            queue_rsp_t       r;
            bit [COUNT_W-1:0] next_tail;
            bit [COUNT_W-1:0] fill;
            bit [COUNT_W-1:0] fill_one;
            r = '0;
            r.status = ST_OK;
            next_tail = tail + 5'd1;
            case (kind)
                REQ_ENQ:
                begin
                    if (next_tail == done_head)
                    begin
                        r.status = ST_FULL;
                        if (dropped != '1)
                            dropped++;
                    end
                    else
                    begin
                        slot_dev[tail] = dev;
                        slot_handle[tail] = handle;
                        tail = next_tail;
                        fill = tail - done_head;
                        fill_one = tail - submit_head;
                        if (fill > peak_total)
                            peak_total = fill;
                        if (fill_one > peak_one)
                            peak_one = fill_one;
                    end
                end
                REQ_ADV:
                begin
                    if (submit_head == tail)
                        r.status = ST_NO_SUBMIT;
                    else
                    begin
                        r.item_dev = slot_dev[submit_head];
                        r.item_handle = slot_handle[submit_head];
                        submit_head++;
                    end
                end
                REQ_DEQ:
                begin
                    if (done_head == submit_head)
                        r.status = ST_NO_DONE;
                    else
                    begin
                        r.item_dev = slot_dev[done_head];
                        r.item_handle = slot_handle[done_head];
                        done_head++;
                    end
                end
                default:
                    ;
            endcase
            r.submit_pending = (submit_head != tail);
            if (r.submit_pending)
            begin
                r.submit_dev = slot_dev[submit_head];
                r.submit_handle = slot_handle[submit_head];
            end
            r.complete_pending = (done_head != submit_head);
            r.count_total = tail - done_head;
            r.count_phase_one = tail - submit_head;
            r.lost_count = dropped;
            r.max_total = peak_total;
            r.max_phase_one = peak_one;
            req_seen[kind]++;
            status_seen[r.status]++;
            due_responses.push_back(r);
        endfunction

        function void compare_field(string field, logic [HANDLE_W-1:0] want,
                                    logic [HANDLE_W-1:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d, %s: expected %0h, got %0h",
                             checked, field, want, got);
            end
        endfunction

        // compare a response against the oldest one owed
        function void check_response(queue_rsp_t got);
            queue_rsp_t want;
            if (due_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response with no request outstanding: %p", got);
                return;
            end
            want = due_responses.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("item_dev", want.item_dev, got.item_dev);
            compare_field("item_handle", want.item_handle, got.item_handle);
            compare_field("submit_pending", want.submit_pending, got.submit_pending);
            compare_field("submit_dev", want.submit_dev, got.submit_dev);
            compare_field("submit_handle", want.submit_handle, got.submit_handle);
            compare_field("complete_pending", want.complete_pending, got.complete_pending);
            compare_field("count_total", want.count_total, got.count_total);
            compare_field("count_phase_one", want.count_phase_one, got.count_phase_one);
            compare_field("lost_count", want.lost_count, got.lost_count);
            compare_field("max_total", want.max_total, got.max_total);
            compare_field("max_phase_one", want.max_phase_one, got.max_phase_one);
            checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tbq_req_if req_ch ();
    tbq_rsp_if rsp_ch ();

    two_phase_tx_buffer_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    tx_ring_tracker sb = new();

    // idle switches for each side, flipped per segment by the stimulus
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // a generous ceiling on the whole run
    initial
    begin
        #(6_000_000);
        $display("timeout with %0d responses still owed", sb.due_responses.size());
        $display("two_phase_tx_buffer_queue_unit_tb: FAIL");
        $finish;
    end

    // response side ready, with random stall bursts
    initial
    begin : recv_side
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (recv_idle_on && $urandom_range(0, 99) < 15)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // response monitor: sample on the rising edge, before the unit updates
    initial
    begin : rsp_monitor
        queue_rsp_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status = status_t'(rsp_ch.status);
                got.item_dev = rsp_ch.item_dev;
                got.item_handle = rsp_ch.item_handle;
                got.submit_pending = rsp_ch.submit_pending;
                got.submit_dev = rsp_ch.submit_dev;
                got.submit_handle = rsp_ch.submit_handle;
                got.complete_pending = rsp_ch.complete_pending;
                got.count_total = rsp_ch.count_total;
                got.count_phase_one = rsp_ch.count_phase_one;
                got.lost_count = rsp_ch.lost_count;
                got.max_total = rsp_ch.max_total;
                got.max_phase_one = rsp_ch.max_phase_one;
                sb.check_response(got);
            end
        end
    end

    // drive one request transaction from a falling edge until accepted,
    // then maybe leave a gap; returns on a falling edge with valid untouched
    // unless a gap was taken
    task automatic send_request(input logic [1:0] kind, input logic [DEV_W-1:0] dev,
                                input logic [HANDLE_W-1:0] handle);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.dev_index <= dev;
        req_ch.buffer_handle <= handle;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.take_request(kind, dev, handle);
        @(negedge clk);
        if (send_idle_on && $urandom_range(0, 99) < 25)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(negedge clk);
        end
    endtask

    // hold off requests until every owed response has come back
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        while (sb.due_responses.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [1:0] pick_kind(mix_t mix);
        int p;
        p = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (p < 70) ? REQ_ENQ : (p < 85) ? REQ_ADV :
                              (p < 97) ? REQ_DEQ : REQ_NONE;
            MIX_DRAIN: return (p < 15) ? REQ_ENQ : (p < 55) ? REQ_ADV :
                              (p < 97) ? REQ_DEQ : REQ_NONE;
            default:   return (p < 35) ? REQ_ENQ : (p < 65) ? REQ_ADV :
                              (p < 96) ? REQ_DEQ : REQ_NONE;
        endcase
    endfunction

    // mostly random handles, now and then the all-zero and all-one ones
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
            return '0;
        if (p == 1)
            return '1;
        return $urandom;
    endfunction

    initial
    begin : stimulus
        int   random_items;
        int   seg_len;
        mix_t mix;

        // every input known from time zero
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ENQ;
        req_ch.dev_index = '0;
        req_ch.buffer_handle = '0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty-queue refusals and the ignored request code
        send_request(REQ_DEQ, 3'd5, 32'h1234_5678);
        send_request(REQ_ADV, 3'd2, 32'h8765_4321);
        send_request(REQ_NONE, 3'd7, '1);
        // field extremes and walking device bits
        send_request(REQ_ENQ, 3'd0, 32'h0000_0000);
        send_request(REQ_ENQ, 3'd7, 32'hFFFF_FFFF);
        send_request(REQ_ENQ, 3'd1, 32'h5555_5555);
        send_request(REQ_ENQ, 3'd2, 32'hAAAA_AAAA);
        send_request(REQ_ENQ, 3'd4, $urandom);
        // ignored code on a populated queue must not disturb it
        send_request(REQ_NONE, 3'd3, $urandom);
        send_request(REQ_ADV, 3'd0, '0);
        send_request(REQ_DEQ, 3'd0, '0);
        // dequeue with phase one populated but phase two empty
        send_request(REQ_DEQ, 3'd6, $urandom);
        send_request(REQ_ADV, 3'd0, '0);
        send_request(REQ_ADV, 3'd0, '0);
        send_request(REQ_ADV, 3'd0, '0);
        send_request(REQ_ADV, 3'd0, '0);
        // advance with phase one empty while completions wait
        send_request(REQ_ADV, 3'd1, $urandom);
        send_request(REQ_DEQ, 3'd0, '0);
        send_request(REQ_DEQ, 3'd0, '0);
        send_request(REQ_DEQ, 3'd0, '0);
        send_request(REQ_DEQ, 3'd0, '0);
        send_request(REQ_DEQ, 3'd0, '0);
        send_request(REQ_ADV, 3'd0, '0);
        wait_for_drain();

        // random segments, each with its own mix and idle pattern; fill
        // segments push the ring to full and wrap the pointers
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            mix = mix_t'($urandom_range(0, 2));
            seg_len = $urandom_range(15, 50);
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            repeat (seg_len)
            begin
                send_request(pick_kind(mix), 3'($urandom_range(0, 7)), pick_handle());
                random_items++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_for_drain();
        end

        // closing stretch without idling: fill up, then a run of
        // enqueues against the full queue
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        repeat (CAPACITY_DEF + 4)
            send_request(REQ_ENQ, 3'($urandom_range(0, 7)), pick_handle());
        repeat (FULL_DROPS)
            send_request(REQ_ENQ, 3'($urandom_range(0, 7)), pick_handle());
        // empty it through both phases, then a short mixed tail
        repeat (CAPACITY_DEF + 2)
            send_request(REQ_ADV, 3'($urandom_range(0, 7)), pick_handle());
        repeat (CAPACITY_DEF + 2)
            send_request(REQ_DEQ, 3'($urandom_range(0, 7)), pick_handle());
        repeat (40)
            send_request(pick_kind(MIX_FLOW), 3'($urandom_range(0, 7)), pick_handle());

        // let the last responses through, then watch for strays
        wait_for_drain();
        repeat (10)
            @(posedge clk);

        $display("covered %0d requests: %0d enqueue, %0d advance, %0d dequeue, %0d ignored",
                 sb.req_seen[0] + sb.req_seen[1] + sb.req_seen[2] + sb.req_seen[3],
                 sb.req_seen[REQ_ENQ], sb.req_seen[REQ_ADV], sb.req_seen[REQ_DEQ],
                 sb.req_seen[REQ_NONE]);
        $display("%0d responses checked; %0d full drops, %0d empty advances, %0d empty dequeues",
                 sb.checked, sb.status_seen[ST_FULL], sb.status_seen[ST_NO_SUBMIT],
                 sb.status_seen[ST_NO_DONE]);
        if (sb.mismatches == 0 && sb.due_responses.size() == 0)
            $display("two_phase_tx_buffer_queue_unit_tb: PASS");
        else
            $display("two_phase_tx_buffer_queue_unit_tb: FAIL");
        $finish;
    end

endmodule
